// ===== rtl/msie_pkg.sv =====
// shared types, constants and helpers for the mips subset executor
package msie_pkg;

	localparam int REGION_BYTES = 65536;
	localparam int REG_COUNT = 32;
	localparam int RIDX_W = $clog2(REG_COUNT);
	localparam int REGION_WORDS = (REGION_BYTES + 3) / 4;
	localparam int WIDX_W = $clog2(REGION_WORDS);
	localparam int MADDR_W = WIDX_W + 2;
	localparam int MEM_DEPTH = 1 << MADDR_W;

	localparam logic [31:0] PC_RESET = 32'h0040_0000;
	localparam logic [31:0] SP_RESET = 32'h8000_0000;
	localparam logic [RIDX_W-1:0] REG_SP = RIDX_W'(29);
	localparam logic [RIDX_W-1:0] REG_RA = RIDX_W'(31);
	localparam logic [RIDX_W-1:0] REG_ZERO = '0;

	localparam logic [11:0] SEL_PROG = 12'h004;
	localparam logic [11:0] SEL_DATA = 12'h100;
	localparam logic [11:0] SEL_STACK = 12'h7FF;
	localparam logic [1:0] RGN_PROG = 2'd0;
	localparam logic [1:0] RGN_DATA = 2'd1;
	localparam logic [1:0] RGN_STACK = 2'd2;

	localparam logic [2:0] OP_STEP = 3'd0;
	localparam logic [2:0] OP_MEM_WRITE = 3'd1;
	localparam logic [2:0] OP_MEM_READ = 3'd2;
	localparam logic [2:0] OP_SET_PC = 3'd3;
	localparam logic [2:0] OP_SET_REG = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOREGION = 2'd1;
	localparam logic [1:0] ST_MISALIGN = 2'd2;
	localparam logic [1:0] ST_SYSCALL = 2'd3;

	// primary opcodes
	localparam logic [5:0] OPC_RTYPE = 6'd0;
	localparam logic [5:0] OPC_REGIMM = 6'd1;
	localparam logic [5:0] OPC_J = 6'd2;
	localparam logic [5:0] OPC_JAL = 6'd3;
	localparam logic [5:0] OPC_BEQ = 6'd4;
	localparam logic [5:0] OPC_BNE = 6'd5;
	localparam logic [5:0] OPC_ADDI = 6'd8;
	localparam logic [5:0] OPC_SLTI = 6'd10;
	localparam logic [5:0] OPC_ANDI = 6'd12;
	localparam logic [5:0] OPC_ORI = 6'd13;
	localparam logic [5:0] OPC_XORI = 6'd14;
	localparam logic [5:0] OPC_LUI = 6'd15;
	localparam logic [5:0] OPC_LB = 6'd32;
	localparam logic [5:0] OPC_LW = 6'd35;
	localparam logic [5:0] OPC_LBU = 6'd36;
	localparam logic [5:0] OPC_SB = 6'd40;
	localparam logic [5:0] OPC_SW = 6'd43;

	// r-format function codes
	localparam logic [5:0] FN_SLL = 6'd0;
	localparam logic [5:0] FN_SRL = 6'd2;
	localparam logic [5:0] FN_SRA = 6'd3;
	localparam logic [5:0] FN_JR = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;
	localparam logic [5:0] FN_AND = 6'd36;
	localparam logic [5:0] FN_OR = 6'd37;
	localparam logic [5:0] FN_XOR = 6'd38;
	localparam logic [5:0] FN_NOR = 6'd39;
	localparam logic [5:0] FN_SLT = 6'd42;

	typedef struct packed {
		logic [2:0] operation;
		logic [31:0] address;
		logic [31:0] value;
		logic [4:0] reg_index;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] pc_after;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] pc_next;
		logic rf_we;
		logic [RIDX_W-1:0] rf_waddr;
		logic [31:0] rf_wdata;
		logic mem_rd;
		logic mem_wr;
		logic is_byte;
		logic load_sext;
		logic syscall;
		logic [31:0] eaddr;
	} exec_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] rgn;
	} chk_t;

	function automatic chk_t region_check(input logic [31:0] addr, input logic word);
		chk_t c;
		logic [20:0] end_off;
		end_off = {1'b0, addr[19:0]} + (word ? 21'd4 : 21'd1);
		c.status = ST_OK;
		c.rgn = RGN_PROG;
		case (addr[31:20])
			SEL_PROG: c.rgn = RGN_PROG;
			SEL_DATA: c.rgn = RGN_DATA;
			SEL_STACK: c.rgn = RGN_STACK;
			default: c.status = ST_NOREGION;
		endcase
		if (end_off > 21'(REGION_BYTES))
			c.status = ST_NOREGION;
		else if (c.status == ST_OK && word && addr[1:0] != 2'b00)
			c.status = ST_MISALIGN;
		return c;
	endfunction

	function automatic logic [MADDR_W-1:0] mem_index(input logic [1:0] rgn,
			input logic [31:0] addr);
		return {rgn, addr[WIDX_W+1:2]};
	endfunction

endpackage

// ===== rtl/msie_ram.sv =====
// generic simple dual port ram with registered read
module msie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/msie_exec.sv =====
// instruction decode, alu and next pc
module msie_exec (
	input logic [31:0] inst,
	input logic [31:0] pc,
	input logic [31:0] a,
	input logic [31:0] b,
	output msie_pkg::exec_t res
);
	import msie_pkg::*;

	logic [5:0] opc;
	logic [5:0] fn;
	logic [RIDX_W-1:0] rt;
	logic [RIDX_W-1:0] rd;
	logic [4:0] sh;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] next;
	logic [31:0] btarget;
	logic [31:0] jtarget;

	assign opc = inst[31:26];
	assign fn = inst[5:0];
	assign rt = inst[20:16];
	assign rd = inst[15:11];
	assign sh = inst[10:6];
	assign simm = {{16{inst[15]}}, inst[15:0]};
	assign zimm = {16'h0000, inst[15:0]};
	assign next = pc + 32'd4;
	assign btarget = next + {simm[29:0], 2'b00};
	assign jtarget = {next[31:28], inst[25:0], 2'b00};

	always_comb begin
		res = '0;
		res.pc_next = next;
		res.rf_waddr = rt;
		res.eaddr = a + simm;
		unique case (opc)
			OPC_RTYPE: begin
				res.rf_waddr = rd;
				res.rf_we = 1'b1;
				case (fn)
					FN_SLL: res.rf_wdata = b << sh;
					FN_SRL: res.rf_wdata = b >> sh;
					FN_SRA: res.rf_wdata = 32'($signed(b) >>> sh);
					FN_ADD: res.rf_wdata = a + b;
					FN_SUB: res.rf_wdata = a - b;
					FN_AND: res.rf_wdata = a & b;
					FN_OR: res.rf_wdata = a | b;
					FN_XOR: res.rf_wdata = a ^ b;
					FN_NOR: res.rf_wdata = ~(a | b);
					FN_SLT: res.rf_wdata = {31'd0, $signed(a) < $signed(b)};
					FN_JR: begin
						res.rf_we = 1'b0;
						res.pc_next = a;
					end
					FN_SYSCALL: begin
						res.rf_we = 1'b0;
						res.syscall = 1'b1;
					end
					default: res.rf_we = 1'b0;
				endcase
			end
			OPC_REGIMM: if (rt == REG_ZERO && a[31]) res.pc_next = btarget;
			OPC_J: res.pc_next = jtarget;
			OPC_JAL: begin
				res.pc_next = jtarget;
				res.rf_we = 1'b1;
				res.rf_waddr = REG_RA;
				res.rf_wdata = next;
			end
			OPC_BEQ: if (a == b) res.pc_next = btarget;
			OPC_BNE: if (a != b) res.pc_next = btarget;
			OPC_ADDI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = a + simm;
			end
			OPC_SLTI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = {31'd0, $signed(a) < $signed(simm)};
			end
			OPC_ANDI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = a & zimm;
			end
			OPC_ORI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = a | zimm;
			end
			OPC_XORI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = a ^ zimm;
			end
			OPC_LUI: begin
				res.rf_we = 1'b1;
				res.rf_wdata = {inst[15:0], 16'h0000};
			end
			OPC_LB: begin
				res.mem_rd = 1'b1;
				res.is_byte = 1'b1;
				res.load_sext = 1'b1;
			end
			OPC_LBU: begin
				res.mem_rd = 1'b1;
				res.is_byte = 1'b1;
			end
			OPC_LW: res.mem_rd = 1'b1;
			OPC_SB: begin
				res.mem_wr = 1'b1;
				res.is_byte = 1'b1;
			end
			OPC_SW: res.mem_wr = 1'b1;
			default: res.rf_we = 1'b0;
		endcase
		if (res.rf_waddr == REG_ZERO)
			res.rf_we = 1'b0;
	end
endmodule

// ===== rtl/mips_subset_instruction_executor_top.sv =====
// Executor for a MIPS32 subset with no delay slot.
// Channel cmd (cmd_valid/cmd_stall/cmd) carries one word per request:
// step one instruction, write or read a memory word, set the pc, or set a
// register. Channel rsp (rsp_valid/rsp_stall/rsp) returns one word per
// request with the read data, the pc afterwards and a status code.
// Requests are handled one at a time by a sequencer around a byte-lane
// memory (program, data and stack regions) and a register file held in
// two ram copies so rs and rt read together.
// Each request passes a start and a done state; a memory read adds a read-data
// state, an instruction step adds decode and execute after the fetch in start,
// and a load adds a write-back state (fetch, register read, execute and data
// access each wait on the synchronous rams).
// The result is held in an output register; the block can take the next
// request while the previous result is still stalled, and only waits at
// its final cycle if a result is still pending.
// Reset sets pc to 0x00400000, all registers to zero except $sp to
// 0x80000000 (by per-register valid bits); memory is undefined until written.
module mips_subset_instruction_executor_top (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input msie_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_stall,
	output msie_pkg::rsp_t rsp
);
	import msie_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RDATA = 3'd2;
	localparam logic [2:0] S_DECODE = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_LOAD = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [31:0] pc_q;
	logic [31:0] rdata_q;
	logic [1:0] status_q;
	logic [31:0] inst_q;
	logic [31:0] eaddr_q;
	logic load_sext_q;
	logic load_byte_q;
	logic [REG_COUNT-1:0] rf_valid_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [MADDR_W-1:0] mem_addr;
	logic [3:0] mem_we;
	logic [3:0][7:0] mem_wdata;
	logic [3:0][7:0] mem_rdata;
	logic [31:0] mem_word;

	logic rf_we;
	logic [RIDX_W-1:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic [RIDX_W-1:0] rf_ra;
	logic [RIDX_W-1:0] rf_rb;
	logic [31:0] rf_da;
	logic [31:0] rf_db;
	logic [31:0] reg_a;
	logic [31:0] reg_b;

	chk_t cmd_chk;
	chk_t fetch_chk;
	chk_t ex_chk;
	exec_t ex;
	logic [7:0] load_byte;
	logic [31:0] load_val;
	logic accept;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign mem_word = {mem_rdata[0], mem_rdata[1], mem_rdata[2], mem_rdata[3]};
	assign cmd_chk = region_check(cmd_q.address, 1'b1);
	assign fetch_chk = region_check(pc_q, 1'b1);
	assign ex_chk = region_check(ex.eaddr, !ex.is_byte);

	// unwritten registers read as their reset value
	assign reg_a = rf_valid_q[inst_q[25:21]] ? rf_da :
		(inst_q[25:21] == REG_SP ? SP_RESET : 32'd0);
	assign reg_b = rf_valid_q[inst_q[20:16]] ? rf_db :
		(inst_q[20:16] == REG_SP ? SP_RESET : 32'd0);

	msie_exec u_exec (
		.inst(inst_q),
		.pc(pc_q),
		.a(reg_a),
		.b(reg_b),
		.res(ex)
	);

	// lane 0 holds the most significant byte of a word
	assign load_byte = mem_rdata[eaddr_q[1:0]];
	assign load_val = !load_byte_q ? mem_word :
		{{24{load_sext_q & load_byte[7]}}, load_byte};

	always_comb begin
		mem_addr = mem_index(cmd_chk.rgn, cmd_q.address);
		mem_we = '0;
		mem_wdata = {cmd_q.value[7:0], cmd_q.value[15:8], cmd_q.value[23:16],
			cmd_q.value[31:24]};
		rf_we = 1'b0;
		rf_waddr = cmd_q.reg_index;
		rf_wdata = cmd_q.value;
		rf_ra = mem_word[25:21];
		rf_rb = mem_word[20:16];
		unique case (state_q)
			S_START: begin
				unique case (cmd_q.operation)
					OP_STEP: mem_addr = mem_index(fetch_chk.rgn, pc_q);
					OP_MEM_WRITE: if (cmd_chk.status == ST_OK) mem_we = 4'hF;
					OP_SET_REG: rf_we = cmd_q.reg_index != REG_ZERO;
					default: rf_we = 1'b0;
				endcase
			end
			S_EXEC: begin
				mem_addr = mem_index(ex_chk.rgn, ex.eaddr);
				if (ex.is_byte)
					mem_wdata = {4{reg_b[7:0]}};
				else
					mem_wdata = {reg_b[7:0], reg_b[15:8], reg_b[23:16], reg_b[31:24]};
				if (ex.mem_wr && ex_chk.status == ST_OK)
					mem_we = ex.is_byte ? (4'b0001 << ex.eaddr[1:0]) : 4'hF;
				rf_we = ex.rf_we;
				rf_waddr = ex.rf_waddr;
				rf_wdata = ex.rf_wdata;
			end
			S_LOAD: begin
				rf_waddr = inst_q[20:16];
				rf_wdata = load_val;
				rf_we = inst_q[20:16] != REG_ZERO;
			end
			default: rf_we = 1'b0;
		endcase
	end

	for (genvar i = 0; i < 4; i++) begin : gen_lane
		msie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
			.clk(clk),
			.we(mem_we[i]),
			.waddr(mem_addr),
			.wdata(mem_wdata[i]),
			.raddr(mem_addr),
			.rdata(mem_rdata[i])
		);
	end

	msie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
		.clk(clk),
		.we(rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.raddr(rf_ra),
		.rdata(rf_da)
	);

	msie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
		.clk(clk),
		.we(rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.raddr(rf_rb),
		.rdata(rf_db)
	);

	always_ff @(posedge clk) begin
		if (accept)
			cmd_q <= cmd;
		if (state_q == S_DECODE)
			inst_q <= mem_word;
		if (state_q == S_EXEC) begin
			eaddr_q <= ex.eaddr;
			load_sext_q <= ex.load_sext;
			load_byte_q <= ex.is_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= PC_RESET;
			rdata_q <= '0;
			status_q <= ST_OK;
			rf_valid_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rf_we)
				rf_valid_q[rf_waddr] <= 1'b1;
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rdata_q <= '0;
						status_q <= ST_OK;
						state_q <= S_START;
					end
				end
				S_START: begin
					unique case (cmd_q.operation)
						OP_STEP: begin
							if (fetch_chk.status != ST_OK) begin
								status_q <= fetch_chk.status;
								state_q <= S_DONE;
							end else begin
								state_q <= S_DECODE;
							end
						end
						OP_MEM_WRITE: begin
							status_q <= cmd_chk.status;
							state_q <= S_DONE;
						end
						OP_MEM_READ: begin
							status_q <= cmd_chk.status;
							state_q <= (cmd_chk.status == ST_OK) ? S_RDATA : S_DONE;
						end
						OP_SET_PC: begin
							pc_q <= cmd_q.address;
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RDATA: begin
					rdata_q <= mem_word;
					state_q <= S_DONE;
				end
				S_DECODE: state_q <= S_EXEC;
				S_EXEC: begin
					pc_q <= ex.pc_next;
					if (ex.mem_rd || ex.mem_wr)
						status_q <= ex_chk.status;
					else if (ex.syscall)
						status_q <= ST_SYSCALL;
					if (ex.mem_rd && ex_chk.status == ST_OK)
						state_q <= S_LOAD;
					else
						state_q <= S_DONE;
				end
				S_LOAD: state_q <= S_DONE;
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q <= '{read_data: rdata_q, pc_after: pc_q, status: status_q};
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != REG_ZERO)
		else $error("register zero written");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_START)
		else $error("accepted word did not start the sequencer");
	a_mem_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we != 4'h0) |-> (state_q == S_START || state_q == S_EXEC))
		else $error("memory write outside an access cycle");
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside the final cycle");
	a_load_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> status_q == ST_OK)
		else $error("load write back after a failed access");
`endif
endmodule
